// File: design/aci_pkg.sv
`default_nettype none
package aci_pkg;

  localparam int MaxEntities = 64;
  localparam int CoordBits   = 24;
  localparam int HitsBits    = 11;
  localparam int CountBits   = 7;

  localparam logic [1:0] OpWrite   = 2'd0;
  localparam logic [1:0] OpCollide = 2'd1;
  localparam logic [1:0] OpMove    = 2'd2;
  localparam logic [1:0] OpRead    = 2'd3;

  localparam logic [1:0] RegCount   = 2'd0;
  localparam logic [1:0] RegGravity = 2'd1;
  localparam logic [1:0] RegGround  = 2'd2;

  localparam logic signed [23:0] GravityReset = -24'sd128000;
  localparam logic signed [23:0] GroundReset  = 24'sd25600;

  typedef struct packed {
    logic [1:0]         operation;
    logic [5:0]         entity_index;
    logic signed [23:0] box_x;
    logic signed [23:0] box_y;
    logic [22:0]        box_w;
    logic [22:0]        box_h;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [23:0] vel_x;
    logic signed [23:0] vel_y;
    logic [15:0]        time_step;
  } in_word_t;

  typedef struct packed {
    logic signed [23:0] out_box_x;
    logic signed [23:0] out_box_y;
    logic [22:0]        out_box_w;
    logic [22:0]        out_box_h;
    logic signed [23:0] out_pos_x;
    logic signed [23:0] out_pos_y;
    logic signed [23:0] out_vel_x;
    logic signed [23:0] out_vel_y;
    logic [10:0]        pair_hits;
  } out_word_t;

  // Datapath commands from the controller.
  typedef enum logic [2:0] {
    CmdNone, CmdWrite, CmdReadA, CmdReadB, CmdPair, CmdMoveRd, CmdMoveWr, CmdClear
  } cmd_e;

  typedef struct packed {
    cmd_e       cmd;
    logic [9:0] idx_a;
    logic [9:0] idx_b;
  } ctl_t;

endpackage
`default_nettype wire

// File: design/aabb_collide_and_integrate.sv
`default_nettype none
// Entity table engine with collision push-apart and motion integration.
// Input words arrive on in_valid_i/in_stall_o; one result word per input leaves
// on out_valid_o/out_stall_i. Configuration is written on cfg_valid_i/cfg_ready_o
// (always ready): 0 entity count, 1 gravity, 2 ground. The user must write it
// only while the block is idle; the block itself does not enforce this.
// The single table read port fetches one entity per cycle for each pair test.
// One word is worked on at a time; input is stalled until its result is
// registered, and a new word can be taken in the cycle its predecessor's result
// is taken, so each word occupies the block for its latency.
// The result register holds while the receiver stalls, and input stays stalled.
// Reset clears the controller and restores the register defaults; the entity
// table is not cleared and must be written before it is used.
module aabb_collide_and_integrate #(
  parameter int MAX_ENTITIES = aci_pkg::MaxEntities
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire aci_pkg::in_word_t  in_word_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output aci_pkg::out_word_t      out_word_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [1:0]         cfg_index_i,
  input  wire logic [23:0]        cfg_data_i
);
  import aci_pkg::*;
  logic [6:0] count_q;
  logic signed [23:0] gravity_q, ground_q;
  ctl_t ctl;
  in_word_t word;
  out_word_t res;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0; gravity_q <= GravityReset; ground_q <= GroundReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegCount: count_q <= cfg_data_i[6:0];
        RegGravity: gravity_q <= cfg_data_i;
        RegGround: ground_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  aci_ctrl #(.MAX_ENTITIES(MAX_ENTITIES)) u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_word_i, .count_i(count_q),
    .ctl_o(ctl), .word_o(word), .res_i(res), .out_valid_o, .out_stall_i, .out_word_o
  );
  aci_datapath #(.MAX_ENTITIES(MAX_ENTITIES)) u_dp (
    .clk_i, .ctl_i(ctl), .word_i(word), .gravity_i(gravity_q), .ground_i(ground_q),
    .res_o(res)
  );
endmodule
`default_nettype wire

// File: design/aci_datapath.sv
`default_nettype none
module aci_datapath #(
  parameter int MAX_ENTITIES = aci_pkg::MaxEntities
) (
  input  wire logic              clk_i,
  input  wire aci_pkg::ctl_t     ctl_i,
  input  wire aci_pkg::in_word_t word_i,
  input  wire logic signed [23:0] gravity_i,
  input  wire logic signed [23:0] ground_i,
  output aci_pkg::out_word_t     res_o
);
  import aci_pkg::*;
  localparam int IW = $clog2(MAX_ENTITIES);
  localparam int CW = CoordBits;
  localparam int WW = CoordBits + 2;
  localparam logic signed [WW-1:0] Hi = WW'((64'sd1 <<< (CW - 1)) - 1);
  localparam logic signed [WW-1:0] Lo = -Hi - WW'(1);

  logic signed [CW-1:0] bx_m [MAX_ENTITIES];
  logic signed [CW-1:0] by_m [MAX_ENTITIES];
  logic [CW-2:0]        bw_m [MAX_ENTITIES];
  logic [CW-2:0]        bh_m [MAX_ENTITIES];
  logic signed [CW-1:0] px_m [MAX_ENTITIES];
  logic signed [CW-1:0] py_m [MAX_ENTITIES];
  logic signed [CW-1:0] vx_m [MAX_ENTITIES];
  logic signed [CW-1:0] vy_m [MAX_ENTITIES];

  logic signed [CW-1:0] rbx_q, rby_q, rpx_q, rpy_q, rvx_q, rvy_q;
  logic [CW-2:0]        rbw_q, rbh_q;
  logic signed [CW-1:0] abx_q, aby_q;
  logic [CW-2:0]        abw_q, abh_q;
  logic signed [CW-1:0] apx_q, apy_q;
  logic [10:0]          hits_q;
  logic signed [CW+16:0] mx_q, my_q, mg_q;
  logic [IW-1:0]        ia, ib;
  logic [IW-1:0]        rb_idx_q;

  function automatic logic signed [CW-1:0] sat(input logic signed [WW-1:0] v);
    if (v > Hi) return CW'(Hi);
    if (v < Lo) return CW'(Lo);
    return v[CW-1:0];
  endfunction

  assign ia = ctl_i.idx_a[IW-1:0];
  assign ib = ctl_i.idx_b[IW-1:0];

  // Pair geometry, a = held entity, b = freshly read entity.
  logic signed [WW-1:0] ar, at, br, bt, ox, oy, half;
  logic hit, x_axis, a_lo;
  logic signed [CW-1:0] na, nb;
  always_comb begin
    ar = WW'(abx_q) + WW'({1'b0, abw_q});
    at = WW'(aby_q) + WW'({1'b0, abh_q});
    br = WW'(rbx_q) + WW'({1'b0, rbw_q});
    bt = WW'(rby_q) + WW'({1'b0, rbh_q});
    hit = !(ar <= WW'(rbx_q) || WW'(abx_q) >= br || at <= WW'(rby_q) || WW'(aby_q) >= bt);
    ox = ((ar < br) ? ar : br) - ((abx_q > rbx_q) ? WW'(abx_q) : WW'(rbx_q));
    oy = ((at < bt) ? at : bt) - ((aby_q > rby_q) ? WW'(aby_q) : WW'(rby_q));
    x_axis = ox < oy;
    half = x_axis ? (ox >>> 1) : (oy >>> 1);
    a_lo = x_axis ? (abx_q < rbx_q) : (aby_q < rby_q);
    if (a_lo) begin
      na = sat((x_axis ? WW'(apx_q) : WW'(apy_q)) - half);
      nb = sat((x_axis ? WW'(rpx_q) : WW'(rpy_q)) + half);
    end else begin
      na = sat((x_axis ? WW'(apx_q) : WW'(apy_q)) + half);
      nb = sat((x_axis ? WW'(rpx_q) : WW'(rpy_q)) - half);
    end
  end

  // Move update from the registered products.
  logic signed [WW-1:0] npy;
  logic signed [CW-1:0] mpx, mpy, mvy;
  logic above;
  always_comb begin
    mpx = sat(WW'(rpx_q) + WW'(mx_q >>> 16));
    npy = WW'(rpy_q) + WW'(my_q >>> 16);
    above = sat(npy) > ground_i;
    mpy = above ? sat(npy) : ground_i;
    mvy = above ? sat(WW'(rvy_q) + WW'(mg_q >>> 16)) : '0;
  end

  always_ff @(posedge clk_i) begin
    case (ctl_i.cmd)
      CmdWrite: begin
        bx_m[ia] <= word_i.box_x;  by_m[ia] <= word_i.box_y;
        bw_m[ia] <= word_i.box_w;  bh_m[ia] <= word_i.box_h;
        px_m[ia] <= word_i.pos_x;  py_m[ia] <= word_i.pos_y;
        vx_m[ia] <= word_i.vel_x;  vy_m[ia] <= word_i.vel_y;
      end
      CmdPair: if (hit) begin
        if (x_axis) begin
          px_m[ia] <= na; px_m[rb_idx_q] <= nb;
        end else begin
          py_m[ia] <= na; py_m[rb_idx_q] <= nb;
        end
      end
      CmdMoveWr: begin
        px_m[ia] <= mpx; py_m[ia] <= mpy; vy_m[ia] <= mvy;
      end
      default: ;
    endcase
  end

  // Read port: register the entry at idx_b; a held copy of entity a for pairs.
  always_ff @(posedge clk_i) begin
    rbx_q <= bx_m[ib]; rby_q <= by_m[ib]; rbw_q <= bw_m[ib]; rbh_q <= bh_m[ib];
    rpx_q <= px_m[ib]; rpy_q <= py_m[ib]; rvx_q <= vx_m[ib]; rvy_q <= vy_m[ib];
    rb_idx_q <= ib;
    mx_q <= vx_m[ib] * $signed({1'b0, word_i.time_step});
    my_q <= vy_m[ib] * $signed({1'b0, word_i.time_step});
    mg_q <= gravity_i * $signed({1'b0, word_i.time_step});
    case (ctl_i.cmd)
      CmdReadA: begin
        abx_q <= rbx_q; aby_q <= rby_q; abw_q <= rbw_q; abh_q <= rbh_q;
        apx_q <= rpx_q; apy_q <= rpy_q;
      end
      CmdPair: if (hit) begin
        if (x_axis) apx_q <= na; else apy_q <= na;
        if (hits_q != 11'h7ff) hits_q <= hits_q + 11'd1;
      end
      CmdClear: hits_q <= '0;
      default: ;
    endcase
  end

  always_comb begin
    res_o = '0;
    res_o.out_box_x = rbx_q; res_o.out_box_y = rby_q;
    res_o.out_box_w = rbw_q; res_o.out_box_h = rbh_q;
    res_o.out_pos_x = rpx_q; res_o.out_pos_y = rpy_q;
    res_o.out_vel_x = rvx_q; res_o.out_vel_y = rvy_q;
    res_o.pair_hits = hits_q;
  end
endmodule
`default_nettype wire

// File: design/aci_ctrl.sv
`default_nettype none
module aci_ctrl #(
  parameter int MAX_ENTITIES = aci_pkg::MaxEntities
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire aci_pkg::in_word_t   in_word_i,
  input  wire logic [6:0]          count_i,
  output aci_pkg::ctl_t            ctl_o,
  output aci_pkg::in_word_t        word_o,
  input  wire aci_pkg::out_word_t  res_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output aci_pkg::out_word_t       out_word_o
);
  import aci_pkg::*;
  typedef enum logic [2:0] {
    StIdle, StReadWait, StPairA, StPairH, StPairB, StMoveRd, StMoveWr, StDone
  } state_e;

  state_e state_q;
  in_word_t word_q;
  logic [9:0] i_q, j_q, n;
  logic rd_zero_q;
  out_word_t out_word_d;

  assign n = (int'(count_i) > MAX_ENTITIES) ? 10'(MAX_ENTITIES) : 10'(count_i);
  assign in_stall_o = (state_q != StIdle) || (out_valid_o && out_stall_i);
  assign word_o = word_q;

  always_comb begin
    ctl_o = '{cmd: CmdNone, idx_a: i_q, idx_b: j_q};
    case (state_q)
      StIdle: if (in_valid_i && !in_stall_o && in_word_i.operation == OpCollide) begin
        ctl_o.cmd = CmdClear;
      end else begin
        ctl_o.idx_b = 10'(in_word_i.entity_index);
      end
      StPairH: ctl_o.cmd = CmdReadA;
      StPairB: ctl_o.cmd = CmdPair;
      StMoveRd: ctl_o.cmd = CmdMoveRd;
      StMoveWr: ctl_o.cmd = CmdMoveWr;
      StDone: if (word_q.operation == OpWrite && !rd_zero_q) begin
        ctl_o.cmd = CmdWrite;
        ctl_o.idx_a = 10'(word_q.entity_index);
      end
      default: ;
    endcase
  end

  always_comb begin
    out_word_d = '0;
    if (word_q.operation == OpRead && !rd_zero_q) begin
      out_word_d = res_i;
      out_word_d.pair_hits = '0;
    end else if (word_q.operation == OpCollide) begin
      out_word_d.pair_hits = res_i.pair_hits;
    end
  end

  // Entity i is fetched, then held while each later entity is read; every pair
  // cycle tests the entry read the cycle before and fetches the next one.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; out_valid_o <= 1'b0; i_q <= '0; j_q <= '0; rd_zero_q <= 1'b0;
    end else begin
      if (state_q == StDone && (!out_valid_o || !out_stall_i)) out_valid_o <= 1'b1;
      else if (out_valid_o && !out_stall_i) out_valid_o <= 1'b0;
      case (state_q)
        StIdle: if (in_valid_i && !in_stall_o) begin
          word_q <= in_word_i;
          rd_zero_q <= int'(in_word_i.entity_index) >= MAX_ENTITIES;
          case (in_word_i.operation)
            OpRead: begin
              j_q <= 10'(in_word_i.entity_index);
              state_q <= StReadWait;
            end
            OpCollide: begin
              i_q <= '0; j_q <= '0;
              state_q <= (n < 10'd2) ? StDone : StPairA;
            end
            OpMove: begin
              i_q <= '0; j_q <= '0;
              state_q <= (n == 10'd0) ? StDone : StMoveRd;
            end
            default: state_q <= StDone;
          endcase
        end
        StReadWait: state_q <= StDone;
        StPairA: begin
          j_q <= i_q + 10'd1; state_q <= StPairH;
        end
        StPairH: begin
          j_q <= j_q + 10'd1; state_q <= StPairB;
        end
        StPairB: begin
          // j_q addresses next entity; comparison happens on registered read.
          if (j_q == n) begin
            if (i_q + 10'd2 >= n) state_q <= StDone;
            else begin
              i_q <= i_q + 10'd1; j_q <= i_q + 10'd1; state_q <= StPairA;
            end
          end else j_q <= j_q + 10'd1;
        end
        StMoveRd: state_q <= StMoveWr;
        StMoveWr: begin
          if (i_q + 10'd1 == n) state_q <= StDone;
          else begin
            i_q <= i_q + 10'd1; j_q <= i_q + 10'd1; state_q <= StMoveRd;
          end
        end
        StDone: if (!out_valid_o || !out_stall_i) begin
          out_word_o <= out_word_d;
          state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: design/aci_checker.sv
`default_nettype none
module aci_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_stall_o,
  input wire logic out_valid_o,
  input wire logic out_stall_i,
  input wire aci_pkg::out_word_t out_word_o
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o)) else $error("hold");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o) else $error("accept while busy");
  a_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i |=> !out_valid_o) else $error("repeat");
endmodule
bind aabb_collide_and_integrate aci_checker u_chk (.*);
`default_nettype wire

// File: bench/aabb_collide_and_integrate_chk.sv
module aabb_collide_and_integrate_chk
  import aci_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  in_word_t    in_word_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  out_word_t   out_word_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i,
  output int          errors_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic signed [23:0] box_x_tab [MaxEntities];
  logic signed [23:0] box_y_tab [MaxEntities];
  logic [22:0]        box_w_tab [MaxEntities];
  logic [22:0]        box_h_tab [MaxEntities];
  logic signed [23:0] pos_x_tab [MaxEntities];
  logic signed [23:0] pos_y_tab [MaxEntities];
  logic signed [23:0] vel_x_tab [MaxEntities];
  logic signed [23:0] vel_y_tab [MaxEntities];

  logic [6:0]         live_count;
  logic signed [23:0] gravity;
  logic signed [23:0] ground;

  out_word_t result_q[$];

  function automatic logic signed [23:0] clamp_coord(longint v);
    if (v > 64'sd8388607) return 24'sh7FFFFF;
    if (v < -64'sd8388608) return 24'sh800000;
    return v[23:0];
  endfunction

  function automatic int live_entities();
    return (live_count > MaxEntities) ? MaxEntities : int'(live_count);
  endfunction

  function automatic logic [10:0] push_apart();
    int n;
    int hits;
    longint ax, ay, ar, at, bx, by, br, bt, ox, oy, half;
    n = live_entities();
    hits = 0;
    for (int i = 0; i < n; i++) begin
      for (int j = i + 1; j < n; j++) begin
        ax = box_x_tab[i]; ay = box_y_tab[i];
        ar = ax + longint'(box_w_tab[i]); at = ay + longint'(box_h_tab[i]);
        bx = box_x_tab[j]; by = box_y_tab[j];
        br = bx + longint'(box_w_tab[j]); bt = by + longint'(box_h_tab[j]);
        if (ar <= bx || ax >= br || at <= by || ay >= bt) continue;
        if (hits < 2047) hits++;
        ox = ((ar < br) ? ar : br) - ((ax > bx) ? ax : bx);
        oy = ((at < bt) ? at : bt) - ((ay > by) ? ay : by);
        if (ox < oy) begin
          half = ox >>> 1;
          if (ax < bx) begin
            pos_x_tab[i] = clamp_coord(pos_x_tab[i] - half);
            pos_x_tab[j] = clamp_coord(pos_x_tab[j] + half);
          end else begin
            pos_x_tab[i] = clamp_coord(pos_x_tab[i] + half);
            pos_x_tab[j] = clamp_coord(pos_x_tab[j] - half);
          end
        end else begin
          // Equal overlaps push along y.
          half = oy >>> 1;
          if (ay < by) begin
            pos_y_tab[i] = clamp_coord(pos_y_tab[i] - half);
            pos_y_tab[j] = clamp_coord(pos_y_tab[j] + half);
          end else begin
            pos_y_tab[i] = clamp_coord(pos_y_tab[i] + half);
            pos_y_tab[j] = clamp_coord(pos_y_tab[j] - half);
          end
        end
      end
    end
    return 11'(hits);
  endfunction

  function automatic void integrate(logic [15:0] step);
    longint dt;
    dt = longint'(step);
    for (int i = 0; i < live_entities(); i++) begin
      pos_x_tab[i] = clamp_coord(pos_x_tab[i] + ((longint'(vel_x_tab[i]) * dt) >>> 16));
      pos_y_tab[i] = clamp_coord(pos_y_tab[i] + ((longint'(vel_y_tab[i]) * dt) >>> 16));
      if (pos_y_tab[i] > ground) begin
        vel_y_tab[i] = clamp_coord(vel_y_tab[i] + ((longint'(gravity) * dt) >>> 16));
      end else begin
        pos_y_tab[i] = ground;
        vel_y_tab[i] = '0;
      end
    end
  endfunction

  function automatic out_word_t apply_word(in_word_t w);
    out_word_t r;
    r = '0;
    case (w.operation)
      OpWrite: begin
        box_x_tab[w.entity_index] = w.box_x;
        box_y_tab[w.entity_index] = w.box_y;
        box_w_tab[w.entity_index] = w.box_w;
        box_h_tab[w.entity_index] = w.box_h;
        pos_x_tab[w.entity_index] = w.pos_x;
        pos_y_tab[w.entity_index] = w.pos_y;
        vel_x_tab[w.entity_index] = w.vel_x;
        vel_y_tab[w.entity_index] = w.vel_y;
      end
      OpCollide: r.pair_hits = push_apart();
      OpMove:    integrate(w.time_step);
      default: begin
        r.out_box_x = box_x_tab[w.entity_index];
        r.out_box_y = box_y_tab[w.entity_index];
        r.out_box_w = box_w_tab[w.entity_index];
        r.out_box_h = box_h_tab[w.entity_index];
        r.out_pos_x = pos_x_tab[w.entity_index];
        r.out_pos_y = pos_y_tab[w.entity_index];
        r.out_vel_x = vel_x_tab[w.entity_index];
        r.out_vel_y = vel_y_tab[w.entity_index];
      end
    endcase
    return r;
  endfunction

  task automatic compare_field(string field, longint want, longint got);
    if (want != got) begin
      errors_o++;
      $display("%t mismatch on %s: expected %0d, actual %0d", $time, field, want, got);
    end
  endtask

  initial errors_o = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t want;
    if (!rst_ni) begin
      live_count <= '0;
      gravity    <= GravityReset;
      ground     <= GroundReset;
      result_q.delete();
      pending_o  <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (result_q.size() == 0) begin
          errors_o++;
          $display("%t result word with nothing expected: actual %h", $time, out_word_i);
        end else begin
          want = result_q.pop_front();
          compare_field("out_box_x", want.out_box_x, out_word_i.out_box_x);
          compare_field("out_box_y", want.out_box_y, out_word_i.out_box_y);
          compare_field("out_box_w", want.out_box_w, out_word_i.out_box_w);
          compare_field("out_box_h", want.out_box_h, out_word_i.out_box_h);
          compare_field("out_pos_x", want.out_pos_x, out_word_i.out_pos_x);
          compare_field("out_pos_y", want.out_pos_y, out_word_i.out_pos_y);
          compare_field("out_vel_x", want.out_vel_x, out_word_i.out_vel_x);
          compare_field("out_vel_y", want.out_vel_y, out_word_i.out_vel_y);
          compare_field("pair_hits", want.pair_hits, out_word_i.pair_hits);
        end
      end
      if (in_valid_i && !in_stall_i) result_q.push_back(apply_word(in_word_i));
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          RegCount:   live_count = cfg_data_i[6:0];
          RegGravity: gravity = cfg_data_i;
          RegGround:  ground = cfg_data_i;
          default: ;
        endcase
      end
      pending_o <= result_q.size();
    end
  end

endmodule

// File: bench/aabb_collide_and_integrate_tb.sv
module aabb_collide_and_integrate_tb;
  import aci_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IdleLimit = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_word_t    in_word = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_word_t   out_word;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = RegCount;
  logic [23:0] cfg_data = '0;

  int  errors;
  int  pending;
  int  idle_mode = 0;      // 0: light sender gaps, 1: heavy sender gaps, 2: none
  logic hold_arm = 1'b0;
  logic hold_done = 1'b0;
  int  hold_left = 0;
  int  quiet_cycles = 0;
  logic written [MaxEntities];
  int  count_now = 0;

  always #5 clk_i = ~clk_i;

  aabb_collide_and_integrate DUT (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_word_i(in_word),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_word_o(out_word),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  aabb_collide_and_integrate_chk u_chk (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_word_i(in_word),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_word_i(out_word),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .errors_o(errors), .pending_o(pending)
  );

  // Receiver side: random stalls, plus one long hold-off so the block backs up.
  always @(posedge clk_i) begin
    if (hold_arm && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= 400;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      case (idle_mode)
        0:       out_stall <= ($urandom_range(0, 99) < 63);
        1:       out_stall <= ($urandom_range(0, 99) < 22);
        default: out_stall <= 1'b0;
      endcase
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IdleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send_word(in_word_t w);
    int gap_pct;
    gap_pct = (idle_mode == 0) ? 22 : (idle_mode == 1) ? 63 : 0;
    if ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < gap_pct);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    if (w.operation == OpWrite) written[w.entity_index] = 1'b1;
    do @(posedge clk_i); while (in_stall);
  endtask

  // Let every outstanding word drain before touching the registers.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic set_reg(logic [1:0] idx, logic [23:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk_i);
    if (idx == RegCount) count_now = (value[6:0] > MaxEntities) ? MaxEntities : value[6:0];
  endtask

  function automatic logic signed [23:0] near_zero(int span);
    return 24'($signed($urandom_range(0, 2 * span)) - span);
  endfunction

  function automatic in_word_t entity_word(logic [5:0] idx, logic signed [23:0] bx,
      logic signed [23:0] by, logic [22:0] bw, logic [22:0] bh, logic signed [23:0] px,
      logic signed [23:0] py, logic signed [23:0] vx, logic signed [23:0] vy);
    in_word_t w;
    w = '0;
    w.operation = OpWrite; w.entity_index = idx;
    w.box_x = bx; w.box_y = by; w.box_w = bw; w.box_h = bh;
    w.pos_x = px; w.pos_y = py; w.vel_x = vx; w.vel_y = vy;
    w.time_step = 16'($urandom);
    return w;
  endfunction

  function automatic in_word_t op_word(logic [1:0] op, logic [5:0] idx, logic [15:0] dt);
    in_word_t w;
    logic [223:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    w = raw[$bits(in_word_t)-1:0];
    w.operation = op; w.entity_index = idx; w.time_step = dt;
    return w;
  endfunction

  // Boxes mostly crowd one small area so that pairs overlap; some are wild.
  function automatic in_word_t random_entity(logic [5:0] idx);
    if ($urandom_range(0, 99) < 25)
      return entity_word(idx, 24'($urandom), 24'($urandom), 23'($urandom), 23'($urandom),
                         24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom));
    return entity_word(idx, near_zero(3000), near_zero(3000),
                       ($urandom_range(0, 9) == 0) ? 23'd0 : 23'($urandom_range(0, 2500)),
                       ($urandom_range(0, 9) == 0) ? 23'd0 : 23'($urandom_range(0, 2500)),
                       near_zero(60000), near_zero(60000), near_zero(200000),
                       near_zero(200000));
  endfunction

  function automatic logic [5:0] written_index();
    logic [5:0] idx;
    do idx = 6'($urandom); while (!written[idx]);
    return idx;
  endfunction

  task automatic random_phase(int items);
    int pick;
    for (int k = 0; k < items; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 35)
        send_word(random_entity(($urandom_range(0, 3) == 0 || count_now == 0) ?
                  6'($urandom) : 6'($urandom_range(0, count_now - 1))));
      else if (pick < 65)
        send_word(op_word(OpRead, written_index(), 16'($urandom)));
      else if (pick < 85)
        send_word(op_word(OpMove, 6'($urandom), ($urandom_range(0, 9) == 0) ?
                  16'($urandom) : 16'($urandom_range(0, 2000))));
      else
        send_word(op_word(OpCollide, 6'($urandom), 16'($urandom)));
      if (k == 10 && idle_mode == 0) hold_arm <= 1'b1;
    end
  endtask

  task automatic fill_table(int upto);
    for (int i = 0; i < upto; i++)
      if (!written[i]) send_word(random_entity(6'(i)));
  endtask

  initial begin
    logic [6:0]  counts [4];
    logic [23:0] gravs [4];
    logic [23:0] grounds [4];
    int          sizes [4];
    counts  = '{7'd8, 7'd16, 7'd2, 7'd127};
    gravs   = '{24'h800000, 24'h7FFFFF, 24'($urandom), 24'(GravityReset)};
    grounds = '{24'h800000, 24'h7FFFFF, 24'($urandom), 24'(GroundReset)};
    sizes   = '{60, 60, 50, 30};
    foreach (written[i]) written[i] = 1'b0;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: a sideways overlap, an exact copy (equal overlaps), a zero-size box
    // inside boxes 0 and 2, and the extremes of every field.
    send_word(entity_word(6'd0, 24'sd0, 24'sd0, 23'd1000, 23'd1000, 24'sd0, 24'sd0,
                          24'sd1000, 24'sd2000));
    send_word(entity_word(6'd1, 24'sd500, 24'sd200, 23'd1000, 23'd1000, 24'sh7FFFFF,
                          24'sh800000, 24'sh7FFFFF, 24'sh800000));
    send_word(entity_word(6'd2, 24'sd0, 24'sd0, 23'd1000, 23'd1000, 24'sd10, 24'sd20,
                          24'sd0, 24'sd0));
    send_word(entity_word(6'd3, 24'sd100, 24'sd100, 23'd0, 23'd0, -24'sd5, 24'sd30000,
                          24'sh800000, 24'sh7FFFFF));
    send_word(entity_word(6'd4, 24'sh800000, 24'sh7FFFFF, 23'h7FFFFF, 23'h7FFFFF,
                          24'sh800000, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh800000));
    send_word(entity_word(6'd63, 24'sh7FFFFF, 24'sh800000, 23'h7FFFFF, 23'd0,
                          24'sh7FFFFF, 24'sh800000, 24'sh800000, 24'sh7FFFFF));
    send_word(op_word(OpCollide, 6'd0, 16'd0));
    send_word(op_word(OpMove, 6'd0, 16'hFFFF));
    send_word(op_word(OpRead, 6'd63, 16'd0));
    send_word(op_word(OpRead, 6'd4, 16'd0));
    drain();
    set_reg(RegCount, 24'd5);
    send_word(op_word(OpCollide, 6'd0, 16'd0));
    for (int i = 0; i < 5; i++) send_word(op_word(OpRead, 6'(i), 16'd0));
    send_word(op_word(OpMove, 6'd0, 16'hFFFF));
    send_word(op_word(OpMove, 6'd0, 16'd0));
    send_word(op_word(OpCollide, 6'd0, 16'd0));
    for (int i = 0; i < 5; i++) send_word(op_word(OpRead, 6'(i), 16'd0));

    for (int p = 0; p < 4; p++) begin
      idle_mode = (p == 0) ? 0 : (p == 1) ? 1 : 2;
      fill_table((counts[p] > MaxEntities) ? MaxEntities : counts[p]);
      drain();
      set_reg(RegCount, 24'(counts[p]));
      set_reg(RegGravity, gravs[p]);
      set_reg(RegGround, grounds[p]);
      set_reg(2'd3, 24'($urandom));
      random_phase(sizes[p]);
    end

    drain();
    repeat (50) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: sim.f
design/aci_pkg.sv
design/aci_datapath.sv
design/aci_ctrl.sv
design/aabb_collide_and_integrate.sv
design/aci_checker.sv
bench/aabb_collide_and_integrate_chk.sv
bench/aabb_collide_and_integrate_tb.sv
